FILE: sv/sqli_pkg.sv
// ----------------------------------------------------------------------------
// sqli_pkg
// Types and constants shared by the sorted query linear interpolator modules.
// ----------------------------------------------------------------------------
package sqli_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_INTERP = 3'd0,
    STATUS_LOW    = 3'd1,
    STATUS_HIGH   = 3'd2,
    STATUS_DEGEN  = 3'd3,
    STATUS_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_LATCH_LO,
    ST_CHECK,
    ST_MULT,
    ST_ROUND,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic j_inc;
    logic rd_lo;
    logic latch_hi;
    logic latch_lo;
    logic setup;
    logic mult;
    logic round_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic j_end;
    logic j_zero;
    logic x_below;
    logic degenerate;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/sqli_ctrl.sv
// ----------------------------------------------------------------------------
// sqli_ctrl
// Sequencer for clear, append and query items: breakpoint search, segment
// fetch, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module sqli_ctrl
  import sqli_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] command,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  assign take = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && cmd_t'(command) == CMD_QUERY) begin
          state_next = stat.count_zero ? ST_DONE : ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        state_next = stat.j_end ? ST_FETCH_HI : ST_SEARCH_CMP;
      end
      ST_SEARCH_CMP: begin
        state_next = stat.x_below ? ST_SEARCH_RD : ST_FETCH_HI;
      end
      ST_FETCH_HI: state_next = ST_FETCH_LO;
      ST_FETCH_LO: state_next = ST_LATCH_LO;
      ST_LATCH_LO: state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.j_zero || stat.j_end || stat.degenerate) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MULT;
        end
      end
      ST_MULT:  state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (stat.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (take) begin
          case (command)
            CMD_CLEAR:  cmd.clear       = 1'b1;
            CMD_APPEND: cmd.append      = 1'b1;
            CMD_QUERY:  cmd.query_start = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_SEARCH_RD:  ;
      ST_SEARCH_CMP: cmd.j_inc = stat.x_below;
      ST_FETCH_HI:   ;
      ST_FETCH_LO: begin
        cmd.rd_lo    = 1'b1;
        cmd.latch_hi = 1'b1;
      end
      ST_LATCH_LO: cmd.latch_lo   = 1'b1;
      ST_CHECK:    cmd.setup      = 1'b1;
      ST_MULT:     cmd.mult       = 1'b1;
      ST_ROUND:    cmd.round_init = 1'b1;
      ST_DIVIDE:   cmd.div_step   = 1'b1;
      ST_DONE:     cmd.load_out   = stat.out_free;
      default:     ;
    endcase
  end

endmodule

FILE: sv/sqli_dp.sv
// ----------------------------------------------------------------------------
// sqli_dp
// Breakpoint memories, search index, segment registers, multiplier,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module sqli_dp
  import sqli_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [DATA_W-1:0] in_x,
  input  logic [DATA_W-1:0] in_y,
  input  logic              new_run,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [DATA_W-1:0] out_y,
  output logic [2:0]        status
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] y_mem [TABLE_DEPTH];

  logic [CW-1:0]     count;
  logic [CW-1:0]     j;
  logic [CW-1:0]     j_dec;
  logic [IW-1:0]     rd_addr;
  logic [DATA_W-1:0] rdata_x;
  logic [DATA_W-1:0] rdata_y;
  logic [DATA_W-1:0] xq;
  logic [DATA_W-1:0] x0;
  logic [DATA_W-1:0] y0;
  logic [DATA_W-1:0] x1;
  logic [DATA_W-1:0] y1;
  logic [DATA_W:0]   span_w;
  logic [DATA_W:0]   dx_w;
  logic [DATA_W:0]   dy_w;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] dx;
  logic [DATA_W:0]   mag;
  logic              neg;
  logic [2*DATA_W:0] prod;
  logic [2*DATA_W:0] prod_full;
  logic [2*DATA_W:0] numer;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   quo;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DATA_W-1:0] lerp_y;
  logic              full;

  assign full    = (count == CW'(TABLE_DEPTH));
  assign j_dec   = j - CW'(1);
  assign rd_addr = cmd.rd_lo ? j_dec[IW-1:0] : j[IW-1:0];

  // breakpoint memories
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      x_mem[count[IW-1:0]] <= in_x;
      y_mem[count[IW-1:0]] <= in_y;
    end
    rdata_x <= x_mem[rd_addr];
    rdata_y <= y_mem[rd_addr];
  end

  // fill count and search index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      j     <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        j     <= '0;
      end else if (cmd.append && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.query_start && new_run) begin
        j <= '0;
      end else if (cmd.j_inc) begin
        j <= j + CW'(1);
      end
    end
  end

  assign span_w = {x1[DATA_W-1], x1} - {x0[DATA_W-1], x0};
  assign dx_w   = {xq[DATA_W-1], xq} - {x0[DATA_W-1], x0};
  assign dy_w   = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};

  assign prod_full = dx * mag;
  assign numer     = prod + {{(DATA_W + 2){1'b0}}, w[DATA_W-1:1]};

  assign trial = {rem, quo[DATA_W]};
  assign ge    = (trial >= {1'b0, w});
  assign diff  = trial - {1'b0, w};

  assign lerp_y = neg ? (y0 - quo[DATA_W-1:0]) : (y0 + quo[DATA_W-1:0]);

  // segment and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      xq <= in_x;
    end
    if (cmd.latch_hi) begin
      x1 <= rdata_x;
      y1 <= rdata_y;
    end
    if (cmd.latch_lo) begin
      x0 <= rdata_x;
      y0 <= rdata_y;
    end
    if (cmd.setup) begin
      w   <= span_w[DATA_W-1:0];
      neg <= dy_w[DATA_W];
      mag <= dy_w[DATA_W] ? (~dy_w + (DATA_W + 1)'(1)) : dy_w;
      if (dx_w[DATA_W]) begin
        dx <= '0;
      end else if (dx_w > span_w) begin
        dx <= span_w[DATA_W-1:0];
      end else begin
        dx <= dx_w[DATA_W-1:0];
      end
    end
    if (cmd.mult) begin
      prod <= prod_full;
    end
    if (cmd.round_init) begin
      rem <= numer[2*DATA_W:DATA_W+1];
      quo <= numer[DATA_W:0];
    end else if (cmd.div_step) begin
      rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.round_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (stat.count_zero) begin
        out_y  <= '0;
        status <= STATUS_EMPTY;
      end else if (stat.j_zero) begin
        out_y  <= y1;
        status <= STATUS_LOW;
      end else if (stat.j_end) begin
        out_y  <= y0;
        status <= STATUS_HIGH;
      end else if (stat.degenerate) begin
        out_y  <= y1;
        status <= STATUS_DEGEN;
      end else begin
        out_y  <= lerp_y;
        status <= STATUS_INTERP;
      end
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.j_end      = (j == count);
  assign stat.j_zero     = (j == '0);
  assign stat.x_below    = ($signed(rdata_x) < $signed(xq));
  assign stat.degenerate = span_w[DATA_W] || (span_w == '0);
  assign stat.div_done   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

FILE: sv/sorted_query_linear_interpolator.sv
// ----------------------------------------------------------------------------
// sorted_query_linear_interpolator
// Piecewise linear interpolation over an appended table of signed Q16.16
// breakpoints, with a forward-only search index for ascending queries.
// ----------------------------------------------------------------------------
// Clear and append items give no result. A query that reaches an empty
// table goes straight to the done state. Any other query first steps the
// search index, one synchronous memory read and one compare per breakpoint
// passed, then ends the search and moves through the fetch and check states
// for the segment; a clamped or degenerate result then goes to the done
// state, while an interpolated one first passes a multiply state, a
// rounding state and the bit-serial divider. In the done state the result
// is loaded once the output register is free. A new item is taken once the
// result is in the output register, which holds it until the consumer
// takes it.
// ----------------------------------------------------------------------------
module sorted_query_linear_interpolator
  import sqli_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // in_x, in_y
  input  logic [2:0]  s_tuser,  // command, new_run
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_y
  output logic [2:0]  m_tuser   // status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sqli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser[1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_x     (s_tdata[31:0]),
    .in_y     (s_tdata[63:32]),
    .new_run  (s_tuser[2]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .out_y    (m_tdata),
    .status   (m_tuser)
  );

`ifndef NO_ASSERTIONS
  // a query holds off further input in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[1:0] == CMD_QUERY) |=> !s_tready)
    else $error("input taken right after a query");

  // a result is only loaded while the block is busy with a query
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while idle");

  // an empty table always gives zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_EMPTY) |-> (m_tdata == '0))
    else $error("empty result with non-zero y");
`endif

endmodule

FILE: bench/sqli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sqli_checker
// Watches the input and output streams of the interpolator. It keeps its own
// breakpoint table and search index, works out the answer that each query
// transfer should produce, and compares every output transfer with the
// oldest outstanding answer.
// ----------------------------------------------------------------------------
module sqli_checker
  import sqli_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,  // in_x, in_y
  input  logic [2:0]  s_tuser,  // command, new_run
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,  // out_y
  input  logic [2:0]  m_tuser,  // status
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] y;
    status_t     st;
  } answer_t;

  answer_t     due_answers[$];
  logic [31:0] bp_x [DEPTH];
  logic [31:0] bp_y [DEPTH];
  int unsigned n_bp;
  int unsigned cursor;

  function automatic logic [31:0] lerp_q16(longint x0, longint y0, longint y1,
                                           longint xq, longint w);
    longint dx;
    longint dy;
    longint r;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned q;
    dx = xq - x0;
    if (dx < 0) dx = 0;
    if (dx > w) dx = w;
    dy = y1 - y0;
    mag = (dy < 0) ? -dy : dy;
    prod = mag * dx;
    // half away from zero on the magnitude
    q = (prod + w / 2) / w;
    r = (dy < 0) ? y0 - q : y0 + q;
    return r[31:0];
  endfunction

  task automatic flag(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic apply_item(input logic [63:0] data, input logic [2:0] user);
    logic [31:0] qx;
    int unsigned j;
    longint x0;
    longint x1;
    longint w;
    answer_t a;
    qx = data[31:0];
    case (user[1:0])
      CMD_CLEAR: begin
        n_bp = 0;
        cursor = 0;
      end
      CMD_APPEND: begin
        if (n_bp < DEPTH) begin
          bp_x[n_bp] = qx;
          bp_y[n_bp] = data[63:32];
          n_bp++;
        end
      end
      CMD_QUERY: begin
        if (user[2]) cursor = 0;
        if (cursor > n_bp) cursor = n_bp;
        if (n_bp == 0) begin
          a = '{32'd0, STATUS_EMPTY};
        end else begin
          j = cursor;
          while (j < n_bp && $signed(bp_x[j]) < $signed(qx)) j++;
          cursor = j;
          if (j == 0) begin
            a = '{bp_y[0], STATUS_LOW};
          end else if (j == n_bp) begin
            a = '{bp_y[n_bp-1], STATUS_HIGH};
          end else begin
            x0 = $signed(bp_x[j-1]);
            x1 = $signed(bp_x[j]);
            w = x1 - x0;
            if (w <= 0) begin
              a = '{bp_y[j], STATUS_DEGEN};
            end else begin
              a = '{lerp_q16(x0, $signed(bp_y[j-1]), $signed(bp_y[j]), $signed(qx), w),
                    STATUS_INTERP};
            end
          end
        end
        due_answers.push_back(a);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    answer_t e;
    if (rst) begin
      n_bp = 0;
      cursor = 0;
      due_answers.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_answers.size() == 0) begin
          flag($sformatf("unexpected transfer: out_y %h status %0d", m_tdata, m_tuser));
        end else begin
          e = due_answers.pop_front();
          if (m_tdata !== e.y)
            flag($sformatf("out_y %h, predicted %h", m_tdata, e.y));
          if (m_tuser !== e.st)
            flag($sformatf("status %0d, predicted %0d", m_tuser, e.st));
        end
      end
      if (s_tvalid && s_tready) apply_item(s_tdata, s_tuser);
    end
    pending = due_answers.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted query linear interpolator: a directed opening on
// empty, clamped, degenerate and out-of-order queries, then random sessions
// of clear, append and ascending query runs under changing idle and stall
// patterns. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module tb
  import sqli_pkg::*;
();

  localparam int DEPTH        = 256;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 362;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint XMIN = -(64'sd1 <<< 31);
  localparam longint XMAX = (64'sd1 <<< 31) - 1;

  typedef enum int {
    PH_DIRECTED,
    PH_STEADY,
    PH_SPARSE_SRC,
    PH_SLOW_SINK,
    PH_MIXED
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic        fresh;
  } op_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  int          errors;
  int          pending;
  int          quiet;
  phase_t      phase;
  op_t         script[$];

  sorted_query_linear_interpolator #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  sqli_checker #(
    .DEPTH(DEPTH)
  ) chk (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v < XMIN) v = XMIN;
    else if (v > XMAX) v = XMAX;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_y();
    if ($urandom_range(0, 9) < 7) return $urandom;
    return clamp32(longint'($urandom_range(0, 2000)) - 1000);
  endfunction

  task automatic put(logic [1:0] c, logic [31:0] x, logic [31:0] y, logic f);
    op_t o;
    o.cmd = c;
    o.x = x;
    o.y = y;
    o.fresh = f;
    script.push_back(o);
  endtask

  // one table build followed by a run of ascending queries
  task automatic session(bit big);
    longint xs[$];
    longint span;
    longint cur;
    longint lo;
    longint hi;
    longint q;
    logic [31:0] qx;
    int k;
    int m;
    int r;
    bit jumbled;
    if (big || $urandom_range(0, 9) != 0)
      put(CMD_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 4))
      0:       span = 2;
      1:       span = 64;
      2:       span = longint'(1) << 16;
      3:       span = longint'(1) << 22;
      default: span = longint'(1) << 28;
    endcase
    if (big) span = longint'(1) << 22;
    r = $urandom_range(0, 9);
    if (big) k = DEPTH + 3;
    else if (r == 0) k = 0;
    else if (r < 8) k = $urandom_range(1, 6);
    else k = $urandom_range(7, 24);
    jumbled = !big && $urandom_range(0, 9) == 0;
    cur = $signed($urandom);
    if (big) cur = XMIN + longint'($urandom_range(0, 1 << 20));
    for (int i = 0; i < k; i++) begin
      if (jumbled) cur = $signed($urandom);
      else if (i > 0) cur = cur + longint'($urandom_range(0, 32'(span)));
      cur = $signed(clamp32(cur));
      xs.push_back(cur);
      if ($urandom_range(0, 19) == 0)
        put(CMD_UNUSED, $urandom, $urandom, 1'($urandom_range(0, 1)));
      put(CMD_APPEND, clamp32(cur), rand_y(), 1'($urandom_range(0, 1)));
    end
    m = big ? 40 : $urandom_range(1, 8);
    if (xs.size() > 0) begin
      lo = xs[0];
      hi = xs[$];
    end else begin
      lo = -1000;
      hi = 1000;
    end
    if (lo > hi) begin
      q = lo;
      lo = hi;
      hi = q;
    end
    lo = lo - span;
    hi = hi + span;
    q = lo;
    for (int i = 0; i < m; i++) begin
      q = q + ((hi - lo) / m) * longint'($urandom_range(0, 1000)) / 1000;
      r = $urandom_range(0, 99);
      if (r < 6) qx = $urandom;
      else if (r < 10) qx = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      else if (r < 25 && xs.size() > 0) qx = clamp32(xs[$urandom_range(0, xs.size() - 1)]);
      else qx = clamp32(q);
      put(CMD_QUERY, qx, $urandom,
          (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0));
    end
    // park the index at the end, then append behind it
    if ($urandom_range(0, 5) == 0) begin
      put(CMD_QUERY, 32'h7fff_ffff, $urandom, 1'b0);
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) begin
        if (xs.size() > 0 && $urandom_range(0, 1))
          qx = clamp32(xs[$] - longint'($urandom_range(0, 1)));
        else
          qx = $urandom;
        put(CMD_APPEND, qx, rand_y(), 1'($urandom_range(0, 1)));
      end
      k = $urandom_range(1, 2);
      for (int i = 0; i < k; i++)
        put(CMD_QUERY, $urandom_range(0, 1) ? 32'h8000_0000 : $urandom, $urandom, 1'b0);
    end
  endtask

  task automatic drive(op_t o);
    int idle_pct;
    idle_pct = (phase == PH_SPARSE_SRC) ? 83 : (phase == PH_MIXED) ? 27 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {o.y, o.x};
    s_tuser  <= {o.fresh, o.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic play(phase_t p);
    phase = p;
    while (script.size() > 0) drive(script.pop_front());
  endtask

  initial begin : stimulus
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    rst      <= 1'b1;
    phase     = PH_DIRECTED;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, then full-scale segments
    put(CMD_CLEAR,  32'h0, 32'h0, 1'b0);
    put(CMD_QUERY,  32'h0, 32'hffff_ffff, 1'b1);
    put(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    put(CMD_APPEND, 32'h0000_0000, 32'h8000_0000, 1'b0);
    put(CMD_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    put(CMD_QUERY,  32'h8000_0000, 32'h0, 1'b1);
    put(CMD_QUERY,  32'hc000_0000, 32'h0, 1'b0);
    put(CMD_QUERY,  32'h0000_0000, 32'h0, 1'b0);
    put(CMD_QUERY,  32'h7fff_ffff, 32'h0, 1'b0);
    // query below the segment without a new run
    put(CMD_QUERY,  32'hffff_0000, 32'h0, 1'b0);
    put(CMD_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 1'b1);
    put(CMD_APPEND, 32'h0000_0000, 32'h000a_0000, 1'b0);
    put(CMD_APPEND, 32'h0064_0000, 32'h0014_0000, 1'b0);
    put(CMD_QUERY,  32'h0032_0000, 32'h0, 1'b1);
    put(CMD_QUERY,  32'h00c8_0000, 32'h0, 1'b0);
    // appended behind the index: falling segment
    put(CMD_APPEND, 32'h0032_0000, 32'h001e_0000, 1'b0);
    put(CMD_QUERY,  32'h0028_0000, 32'h0, 1'b0);
    put(CMD_QUERY,  32'h03e8_0000, 32'h0, 1'b0);
    // zero-width segment
    put(CMD_APPEND, 32'h0032_0000, 32'hfff6_0000, 1'b0);
    put(CMD_QUERY,  32'h000a_0000, 32'h0, 1'b0);
    put(CMD_UNUSED, 32'h1234_5678, 32'h9abc_def0, 1'b1);
    put(CMD_QUERY,  32'h0001_0000, 32'h0, 1'b1);
    play(PH_DIRECTED);

    for (int p = PH_STEADY; p <= PH_MIXED; p++) begin
      if (p == PH_STEADY) session(1'b1);
      while (script.size() < PHASE_ITEMS) session(1'b0);
      play(phase_t'(p));
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("sorted_query_linear_interpolator: match");
    else
      $display("sorted_query_linear_interpolator: mismatch");
    $finish;
  end

  initial begin : sink
    int hold_left;
    int stall_pct;
    bit held;
    hold_left = 0;
    held = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      // long hold-off so the block backs up onto its input
      if (!held && phase == PH_STEADY) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (phase == PH_SLOW_SINK) ? 83 : (phase == PH_MIXED) ? 27 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin : watchdog
    wait (quiet >= QUIET_LIMIT);
    $display("sorted_query_linear_interpolator: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
sv/sqli_pkg.sv
sv/sqli_ctrl.sv
sv/sqli_dp.sv
sv/sorted_query_linear_interpolator.sv
bench/sqli_checker.sv
bench/tb.sv
